// ----- src/fwrl_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed-window rate limiter package
// Shared constants, codes, types and control structs of the limiter.
// ----------------------------------------------------------------------------
package fwrl_pkg;

   localparam int CLIENTS       = 16;
   localparam int LIMITED_SLOTS = 4;
   localparam int TABLE_DEPTH   = CLIENTS * LIMITED_SLOTS;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int SLOT_IDX_W    = (LIMITED_SLOTS > 1) ? $clog2(LIMITED_SLOTS) : 1;

   localparam int TIME_W  = 32;
   localparam int CNT_W   = 16;
   localparam int REC_W   = TIME_W + CNT_W;
   localparam int STAT_W  = 32;
   localparam int ACT_W   = 7;

   localparam logic [TIME_W-1:0] CLEANUP_PERIOD_MS = 32'd60000;
   localparam logic [TIME_W-1:0] RECORD_MAX_AGE_MS = 32'd60000;

   // Item codes on the mode field.
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_REQUEST      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEANUP      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLIENT_RESET = 2'd2;

   localparam int CLIENT_W = 4;
   localparam int SLOT_W   = 3;

   // Configuration port: even index is the request maximum, odd index the window.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CFG_REGS   = 2 * LIMITED_SLOTS;
   localparam logic CSR_SEL_MAX    = 1'b0;
   localparam logic CSR_SEL_WINDOW = 1'b1;

   typedef logic [CNT_W-1:0] slot_word_type [LIMITED_SLOTS];

   localparam slot_word_type MAX_REQ_RESET = '{16'd10, 16'd5, 16'd3, 16'd10};
   localparam slot_word_type WINDOW_RESET  = '{16'd10000, 16'd30000, 16'd60000, 16'd30000};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQ,
      ST_CLN_RD,
      ST_CLN_EVAL,
      ST_CLR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic rd_en;
      logic rd_sweep;
      logic req_commit;
      logic clean_start;
      logic clean_eval;
      logic client_clear;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic in_cleanup_due;
      logic sweep_last;
   } status_type;

endpackage

// ----- src/fixed_window_rate_limiter.sv -----
// ----------------------------------------------------------------------------
// Fixed-window rate limiter
// Per-client, per-endpoint request limiter with periodic cleanup and client
// reset, reporting request statistics with every result.
// ----------------------------------------------------------------------------
// Request: one read-modify-write of the record RAM, read on acceptance, written in
//    ST_REQ once the result register is free; new items are taken only in ST_IDLE.
// Cleanup that runs: ST_CLN_RD and ST_CLN_EVAL for each of the 64 table entries.
// Client reset: ST_CLR, then ST_DONE; ignored items and skipped cleanups: ST_DONE.
// Sync reset clears valid bits and counters, loads reset limits; no clear pass.
module fixed_window_rate_limiter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [fwrl_pkg::MODE_W-1:0]     req_mode,
   input  logic [fwrl_pkg::CLIENT_W-1:0]   req_client_index,
   input  logic [fwrl_pkg::SLOT_W-1:0]     req_endpoint_slot,
   input  logic [fwrl_pkg::TIME_W-1:0]     req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_allowed,
   output logic [fwrl_pkg::ACT_W-1:0]      rsp_removed_count,
   output logic [fwrl_pkg::STAT_W-1:0]     rsp_total_requests,
   output logic [fwrl_pkg::STAT_W-1:0]     rsp_blocked_requests,
   output logic [fwrl_pkg::ACT_W-1:0]      rsp_active_records,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fwrl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fwrl_pkg::CSR_DATA_W-1:0] csr_data
);

   fwrl_pkg::cmd_type    cmd;
   fwrl_pkg::status_type status;

   // Limit registers are written only while the block is idle.
   assign csr_ready = req_ready;

   fwrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fwrl_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_client_index     (req_client_index),
      .req_endpoint_slot    (req_endpoint_slot),
      .req_now_ms           (req_now_ms),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .status               (status),
      .rsp_allowed          (rsp_allowed),
      .rsp_removed_count    (rsp_removed_count),
      .rsp_total_requests   (rsp_total_requests),
      .rsp_blocked_requests (rsp_blocked_requests),
      .rsp_active_records   (rsp_active_records)
   );

endmodule

// ----- src/fwrl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module fwrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fwrl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Rate limiter controller
// Sequences request updates, cleanup sweeps and client resets, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module fwrl_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fwrl_pkg::MODE_W-1:0] req_mode,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  fwrl_pkg::status_type        status,
   output fwrl_pkg::cmd_type           cmd
);

   fwrl_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_xfer;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_xfer = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fwrl_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         fwrl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.rd_en     = 1'b1;
               priority case (req_mode)
                  fwrl_pkg::MODE_REQUEST: begin
                     state_in = fwrl_pkg::ST_REQ;
                  end
                  fwrl_pkg::MODE_CLEANUP: begin
                     if (status.in_cleanup_due) begin
                        cmd.clean_start = 1'b1;
                        state_in        = fwrl_pkg::ST_CLN_RD;
                     end else begin
                        state_in = fwrl_pkg::ST_DONE;
                     end
                  end
                  fwrl_pkg::MODE_CLIENT_RESET: begin
                     state_in = fwrl_pkg::ST_CLR;
                  end
                  default: begin
                     state_in = fwrl_pkg::ST_DONE;
                  end
               endcase
            end
         end
         fwrl_pkg::ST_REQ: begin
            if (out_free) begin
               cmd.req_commit = 1'b1;
               cmd.out_load   = 1'b1;
               state_in       = fwrl_pkg::ST_IDLE;
            end
         end
         fwrl_pkg::ST_CLN_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sweep = 1'b1;
            state_in     = fwrl_pkg::ST_CLN_EVAL;
         end
         fwrl_pkg::ST_CLN_EVAL: begin
            cmd.clean_eval = 1'b1;
            state_in = status.sweep_last ? fwrl_pkg::ST_DONE : fwrl_pkg::ST_CLN_RD;
         end
         fwrl_pkg::ST_CLR: begin
            cmd.client_clear = 1'b1;
            state_in         = fwrl_pkg::ST_DONE;
         end
         fwrl_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = fwrl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fwrl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result never overwrites one that has not been transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");

   // With the result register empty, a request result follows ST_REQ without a stall.
   a_req_latency: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_mode == fwrl_pkg::MODE_REQUEST && !rsp_valid_ff) |=> ##1 rsp_valid_ff)
      else $error("request result late");

   // Table commands are never issued while a new item is being taken.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !(cmd.req_commit || cmd.clean_eval || cmd.client_clear))
      else $error("table update overlaps item acceptance");

endmodule

// ----- src/fwrl_datapath.sv -----
// ----------------------------------------------------------------------------
// Rate limiter datapath
// Limit registers, record table, record valid bits, statistics counters and
// the result register.
// ----------------------------------------------------------------------------
module fwrl_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fwrl_pkg::CLIENT_W-1:0]   req_client_index,
   input  logic [fwrl_pkg::SLOT_W-1:0]     req_endpoint_slot,
   input  logic [fwrl_pkg::TIME_W-1:0]     req_now_ms,
   input  logic                            csr_write,
   input  logic [fwrl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fwrl_pkg::CSR_DATA_W-1:0] csr_data,
   input  fwrl_pkg::cmd_type               cmd,
   output fwrl_pkg::status_type            status,
   output logic                            rsp_allowed,
   output logic [fwrl_pkg::ACT_W-1:0]      rsp_removed_count,
   output logic [fwrl_pkg::STAT_W-1:0]     rsp_total_requests,
   output logic [fwrl_pkg::STAT_W-1:0]     rsp_blocked_requests,
   output logic [fwrl_pkg::ACT_W-1:0]      rsp_active_records
);

   localparam int IDX_W  = fwrl_pkg::IDX_W;
   localparam int TIME_W = fwrl_pkg::TIME_W;
   localparam int CNT_W  = fwrl_pkg::CNT_W;
   localparam int REC_W  = fwrl_pkg::REC_W;
   localparam int STAT_W = fwrl_pkg::STAT_W;
   localparam int ACT_W  = fwrl_pkg::ACT_W;
   localparam int SIW    = fwrl_pkg::SLOT_IDX_W;

   fwrl_pkg::slot_word_type max_ff, max_in;
   fwrl_pkg::slot_word_type win_ff, win_in;

   logic [fwrl_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [STAT_W-1:0] total_ff, total_in;
   logic [STAT_W-1:0] blocked_ff, blocked_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [ACT_W-1:0]  active_ff, active_in;
   logic [ACT_W-1:0]  removed_ff, removed_in;
   logic [IDX_W-1:0]  sweep_ff, sweep_in;

   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [SIW-1:0]    slot_ff, slot_in;
   logic [fwrl_pkg::CLIENT_W-1:0] client_ff, client_in;
   logic limited_ff, limited_in;
   logic client_ok_ff, client_ok_in;

   logic              out_allowed_ff, out_allowed_in;
   logic [ACT_W-1:0]  out_removed_ff, out_removed_in;
   logic [STAT_W-1:0] out_total_ff, out_total_in;
   logic [STAT_W-1:0] out_blocked_ff, out_blocked_in;
   logic [ACT_W-1:0]  out_active_ff, out_active_in;

   logic              port_client_ok;
   logic              port_slot_ok;
   logic [IDX_W-1:0]  port_idx;
   logic [IDX_W-1:0]  rd_addr;
   logic [REC_W-1:0]  rd_data;
   logic              wr_en;
   logic [REC_W-1:0]  wr_data;
   logic [TIME_W-1:0] rd_start;
   logic [CNT_W-1:0]  rd_cnt;
   logic              rec_valid;
   logic [TIME_W-1:0] cur_start;
   logic [CNT_W-1:0]  cur_cnt;
   logic              restart;
   logic              block;
   logic              allow_calc;
   logic [CNT_W-1:0]  new_cnt;
   logic [TIME_W-1:0] new_start;
   logic [SIW-1:0]    csr_slot;

   assign port_client_ok = 32'(req_client_index) < fwrl_pkg::CLIENTS;
   assign port_slot_ok   = 32'(req_endpoint_slot) < fwrl_pkg::LIMITED_SLOTS;
   assign port_idx = IDX_W'(32'(req_client_index) * fwrl_pkg::LIMITED_SLOTS
                            + 32'(req_endpoint_slot));
   assign rd_addr  = cmd.rd_sweep ? sweep_ff : port_idx;

   assign status.in_cleanup_due = (req_now_ms - last_ff) >= fwrl_pkg::CLEANUP_PERIOD_MS;
   assign status.sweep_last     = sweep_ff == IDX_W'(fwrl_pkg::TABLE_DEPTH - 1);

   fwrl_ram #(
      .WIDTH(REC_W),
      .DEPTH(fwrl_pkg::TABLE_DEPTH)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Record check: a record that is not valid reads as freshly created.
   assign rd_start   = rd_data[REC_W-1 -: TIME_W];
   assign rd_cnt     = rd_data[CNT_W-1:0];
   assign rec_valid  = valid_ff[idx_ff];
   assign cur_start  = rec_valid ? rd_start : now_ff;
   assign cur_cnt    = rec_valid ? rd_cnt : '0;
   assign restart    = (now_ff - cur_start) > TIME_W'(win_ff[slot_ff]);
   assign block      = !restart && (cur_cnt >= max_ff[slot_ff]);
   assign allow_calc = !(limited_ff && block);
   assign new_start  = restart ? now_ff : cur_start;
   assign new_cnt    = restart ? CNT_W'(1) : (block ? cur_cnt : cur_cnt + CNT_W'(1));
   assign wr_en      = cmd.req_commit && limited_ff;
   assign wr_data    = {new_start, new_cnt};
   assign csr_slot   = SIW'(csr_index >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= fwrl_pkg::MAX_REQ_RESET;
         win_ff     <= fwrl_pkg::WINDOW_RESET;
         valid_ff   <= '0;
         total_ff   <= '0;
         blocked_ff <= '0;
         last_ff    <= '0;
         active_ff  <= '0;
         removed_ff <= '0;
         sweep_ff   <= '0;
      end else begin
         max_ff     <= max_in;
         win_ff     <= win_in;
         valid_ff   <= valid_in;
         total_ff   <= total_in;
         blocked_ff <= blocked_in;
         last_ff    <= last_in;
         active_ff  <= active_in;
         removed_ff <= removed_in;
         sweep_ff   <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      idx_ff         <= idx_in;
      slot_ff        <= slot_in;
      client_ff      <= client_in;
      limited_ff     <= limited_in;
      client_ok_ff   <= client_ok_in;
      out_allowed_ff <= out_allowed_in;
      out_removed_ff <= out_removed_in;
      out_total_ff   <= out_total_in;
      out_blocked_ff <= out_blocked_in;
      out_active_ff  <= out_active_in;
   end

   always_comb begin
      max_in = max_ff;
      win_in = win_ff;
      if (csr_write && 32'(csr_index) < fwrl_pkg::CFG_REGS) begin
         if (csr_index[0] == fwrl_pkg::CSR_SEL_WINDOW) begin
            win_in[csr_slot] = csr_data;
         end else begin
            max_in[csr_slot] = csr_data;
         end
      end
   end

   always_comb begin
      logic [IDX_W-1:0] cidx;
      cidx         = '0;
      valid_in     = valid_ff;
      total_in     = total_ff;
      blocked_in   = blocked_ff;
      last_in      = last_ff;
      active_in    = active_ff;
      removed_in   = removed_ff;
      sweep_in     = sweep_ff;
      now_in       = now_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      client_in    = client_ff;
      limited_in   = limited_ff;
      client_ok_in = client_ok_ff;

      if (cmd.load_item) begin
         now_in       = req_now_ms;
         idx_in       = port_idx;
         slot_in      = SIW'(req_endpoint_slot);
         client_in    = req_client_index;
         limited_in   = port_slot_ok && port_client_ok;
         client_ok_in = port_client_ok;
         removed_in   = '0;
      end

      if (cmd.clean_start) begin
         last_in  = req_now_ms;
         sweep_in = '0;
      end

      if (cmd.req_commit) begin
         total_in = total_ff + STAT_W'(1);
         if (limited_ff) begin
            valid_in[idx_ff] = 1'b1;
            if (!rec_valid) begin
               active_in = active_ff + ACT_W'(1);
            end
            if (block) begin
               blocked_in = blocked_ff + STAT_W'(1);
            end
         end
      end

      if (cmd.clean_eval) begin
         if (valid_ff[sweep_ff] && (now_ff - rd_start) > fwrl_pkg::RECORD_MAX_AGE_MS) begin
            valid_in[sweep_ff] = 1'b0;
            active_in  = active_ff - ACT_W'(1);
            removed_in = removed_ff + ACT_W'(1);
         end
         sweep_in = sweep_ff + IDX_W'(1);
      end

      if (cmd.client_clear && client_ok_ff) begin
         for (int s = 0; s < fwrl_pkg::LIMITED_SLOTS; s++) begin
            cidx = IDX_W'(32'(client_ff) * fwrl_pkg::LIMITED_SLOTS + s);
            if (valid_ff[cidx]) begin
               valid_in[cidx] = 1'b0;
               active_in  = active_in - ACT_W'(1);
               removed_in = removed_in + ACT_W'(1);
            end
         end
      end
   end

   always_comb begin
      out_allowed_in = out_allowed_ff;
      out_removed_in = out_removed_ff;
      out_total_in   = out_total_ff;
      out_blocked_in = out_blocked_ff;
      out_active_in  = out_active_ff;
      if (cmd.out_load) begin
         out_allowed_in = cmd.req_commit ? allow_calc : 1'b1;
         out_removed_in = removed_in;
         out_total_in   = total_in;
         out_blocked_in = blocked_in;
         out_active_in  = active_in;
      end
   end

   assign rsp_allowed          = out_allowed_ff;
   assign rsp_removed_count    = out_removed_ff;
   assign rsp_total_requests   = out_total_ff;
   assign rsp_blocked_requests = out_blocked_ff;
   assign rsp_active_records   = out_active_ff;

   // The active count always matches the number of valid records.
   a_active_matches: assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) == $countones(valid_ff))
      else $error("active record count out of step with valid bits");

   // A table write always leaves the written record valid.
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(idx_ff)])
      else $error("written record not marked valid");

endmodule

// ----- tb/sv/rate_limit_checker.sv -----
// ----------------------------------------------------------------------------
// Rate limiter result checker
// Watches the request, result and register channels of the limiter, keeps its
// own copy of the record table and statistics, predicts the result of every
// accepted request item and compares each result transfer against it.
// ----------------------------------------------------------------------------
module rate_limit_checker
   import fwrl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [CLIENT_W-1:0]   req_client_index,
   input  logic [SLOT_W-1:0]     req_endpoint_slot,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_allowed,
   input  logic [ACT_W-1:0]      rsp_removed_count,
   input  logic [STAT_W-1:0]     rsp_total_requests,
   input  logic [STAT_W-1:0]     rsp_blocked_requests,
   input  logic [ACT_W-1:0]      rsp_active_records,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              allowed;
      logic [ACT_W-1:0]  removed;
      logic [STAT_W-1:0] total;
      logic [STAT_W-1:0] blocked;
      logic [ACT_W-1:0]  active;
   } limit_outcome_t;

   limit_outcome_t   expected_outcomes [$];

   logic [CNT_W-1:0]  max_per_window [LIMITED_SLOTS];
   logic [CNT_W-1:0]  window_len     [LIMITED_SLOTS];
   bit                rec_live       [TABLE_DEPTH];
   logic [TIME_W-1:0] rec_start      [TABLE_DEPTH];
   logic [CNT_W-1:0]  rec_hits       [TABLE_DEPTH];
   logic [STAT_W-1:0] seen_total;
   logic [STAT_W-1:0] seen_blocked;
   logic [TIME_W-1:0] last_sweep;
   int                live_records;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   function automatic void drop_entry(int idx);
      rec_live[idx] = 1'b0;
      if (live_records > 0) live_records--;
   endfunction

   // Advances the local copy of the limiter by one item and returns its result.
   function automatic limit_outcome_t apply_item(logic [MODE_W-1:0]   mode,
                                                 logic [CLIENT_W-1:0] client,
                                                 logic [SLOT_W-1:0]   slot,
                                                 logic [TIME_W-1:0]   now);
      limit_outcome_t res;
      int             idx;
      int             removed;
      int             i;
      res.allowed = 1'b1;
      removed     = 0;
      case (mode)
         MODE_REQUEST: begin
            seen_total++;
            if (slot < LIMITED_SLOTS && client < CLIENTS) begin
               idx = client * LIMITED_SLOTS + slot;
               if (!rec_live[idx]) begin
                  rec_live[idx]  = 1'b1;
                  rec_start[idx] = now;
                  rec_hits[idx]  = '0;
                  live_records++;
               end
               if (TIME_W'(now - rec_start[idx]) > TIME_W'(window_len[slot])) begin
                  rec_start[idx] = now;
                  rec_hits[idx]  = CNT_W'(1);
               end else if (rec_hits[idx] >= max_per_window[slot]) begin
                  seen_blocked++;
                  res.allowed = 1'b0;
               end else begin
                  rec_hits[idx]++;
               end
            end
         end
         MODE_CLEANUP: begin
            if (TIME_W'(now - last_sweep) >= CLEANUP_PERIOD_MS) begin
               last_sweep = now;
               for (i = 0; i < TABLE_DEPTH; i++) begin
                  if (rec_live[i] && TIME_W'(now - rec_start[i]) > RECORD_MAX_AGE_MS) begin
                     drop_entry(i);
                     removed++;
                  end
               end
            end
         end
         MODE_CLIENT_RESET: begin
            if (client < CLIENTS) begin
               for (i = 0; i < LIMITED_SLOTS; i++) begin
                  idx = client * LIMITED_SLOTS + i;
                  if (rec_live[idx]) begin
                     drop_entry(idx);
                     removed++;
                  end
               end
            end
         end
         default: ;
      endcase
      res.removed = removed[ACT_W-1:0];
      res.total   = seen_total;
      res.blocked = seen_blocked;
      res.active  = live_records[ACT_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      limit_outcome_t want;
      limit_outcome_t got;
      if (reset) begin
         for (int i = 0; i < LIMITED_SLOTS; i++) begin
            max_per_window[i] = MAX_REQ_RESET[i];
            window_len[i]     = WINDOW_RESET[i];
         end
         for (int i = 0; i < TABLE_DEPTH; i++) rec_live[i] = 1'b0;
         seen_total   = '0;
         seen_blocked = '0;
         last_sweep   = '0;
         live_records = 0;
         expected_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index[0] == CSR_SEL_MAX)
               max_per_window[csr_index[CSR_IDX_W-1:1]] = csr_data;
            else
               window_len[csr_index[CSR_IDX_W-1:1]] = csr_data;
         end
         // A result leaving at this edge always belongs to an older item, so it
         // is matched before the request accepted at the same edge is queued.
         if (rsp_valid && rsp_ready) begin
            got.allowed = rsp_allowed;
            got.removed = rsp_removed_count;
            got.total   = rsp_total_requests;
            got.blocked = rsp_blocked_requests;
            got.active  = rsp_active_records;
            if (expected_outcomes.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%t: result transfer with nothing expected: allowed=%0d removed=%0d total=%0d blocked=%0d active=%0d",
                           $realtime, got.allowed, got.removed, got.total, got.blocked,
                           got.active);
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (got.allowed !== want.allowed || got.removed !== want.removed ||
                   got.total !== want.total || got.blocked !== want.blocked ||
                   got.active !== want.active) begin
                  if (mismatch_count < 10)
                     $display("%t: result mismatch: expected allowed=%0d removed=%0d total=%0d blocked=%0d active=%0d, got allowed=%0d removed=%0d total=%0d blocked=%0d active=%0d",
                              $realtime, want.allowed, want.removed, want.total,
                              want.blocked, want.active, got.allowed, got.removed,
                              got.total, got.blocked, got.active);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_outcomes.push_back(apply_item(req_mode, req_client_index,
                                                   req_endpoint_slot, req_now_ms));
      end
      pending_count = expected_outcomes.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Rate limiter testbench
// Drives directed and random request, cleanup and client reset items into the
// limiter under several limit settings and handshake stall patterns, and lets
// the checker compare every result against its own prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fwrl_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 140;
   localparam int DRAIN_LIMIT     = 50000;

   typedef enum int {
      LIMITS_DIRECTED,
      LIMITS_DEFAULT,
      LIMITS_TIGHT,
      LIMITS_EXTREME,
      LIMITS_MIXED
   } limit_style_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode;
   logic [CLIENT_W-1:0]   req_client_index;
   logic [SLOT_W-1:0]     req_endpoint_slot;
   logic [TIME_W-1:0]     req_now_ms;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_allowed;
   logic [ACT_W-1:0]      rsp_removed_count;
   logic [STAT_W-1:0]     rsp_total_requests;
   logic [STAT_W-1:0]     rsp_blocked_requests;
   logic [ACT_W-1:0]      rsp_active_records;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int                    mismatch_count;
   int                    pending_count;
   int                    send_idle_pct;
   int                    recv_stall_pct;
   bit                    hold_off_pending;
   logic [TIME_W-1:0]     sim_ms;

   fixed_window_rate_limiter u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_client_index     (req_client_index),
      .req_endpoint_slot    (req_endpoint_slot),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_allowed          (rsp_allowed),
      .rsp_removed_count    (rsp_removed_count),
      .rsp_total_requests   (rsp_total_requests),
      .rsp_blocked_requests (rsp_blocked_requests),
      .rsp_active_records   (rsp_active_records),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   rate_limit_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_client_index     (req_client_index),
      .req_endpoint_slot    (req_endpoint_slot),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_allowed          (rsp_allowed),
      .rsp_removed_count    (rsp_removed_count),
      .rsp_total_requests   (rsp_total_requests),
      .rsp_blocked_requests (rsp_blocked_requests),
      .rsp_active_records   (rsp_active_records),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: random stalls, or one long hold-off when asked for.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready        = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Leaves valid high after the transfer so back-to-back items need no toggle.
   task automatic offer_item(logic [MODE_W-1:0] mode, logic [CLIENT_W-1:0] client,
                             logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] now);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode          = mode;
      req_client_index  = client;
      req_endpoint_slot = slot;
      req_now_ms        = now;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_limits(limit_style_t style);
      logic [CNT_W-1:0] max_val;
      logic [CNT_W-1:0] win_val;
      for (int s = 0; s < LIMITED_SLOTS; s++) begin
         case (style)
            LIMITS_DIRECTED: begin
               case (s)
                  0:       begin max_val = 16'd0;     win_val = 16'd0;     end
                  1:       begin max_val = 16'd65535; win_val = 16'd65535; end
                  2:       begin max_val = 16'd2;     win_val = 16'd100;   end
                  default: begin max_val = 16'd1;     win_val = 16'd60000; end
               endcase
            end
            LIMITS_DEFAULT: begin
               max_val = MAX_REQ_RESET[s];
               win_val = WINDOW_RESET[s];
            end
            LIMITS_TIGHT: begin
               max_val = CNT_W'($urandom_range(4));
               win_val = CNT_W'($urandom_range(300));
            end
            LIMITS_EXTREME: begin
               case ($urandom_range(2))
                  0:       max_val = 16'd0;
                  1:       max_val = 16'd1;
                  default: max_val = 16'd65535;
               endcase
               case ($urandom_range(2))
                  0:       win_val = 16'd0;
                  1:       win_val = 16'd60000;
                  default: win_val = 16'd65535;
               endcase
            end
            default: begin
               max_val = CNT_W'($urandom_range(30));
               win_val = CNT_W'($urandom_range(65535));
            end
         endcase
         write_reg({s[SLOT_IDX_W-1:0], CSR_SEL_MAX}, max_val);
         write_reg({s[SLOT_IDX_W-1:0], CSR_SEL_WINDOW}, win_val);
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Lets every result come back and the block finish any table sweep.
   task automatic drain();
      int waited;
      @(negedge clock);
      req_valid = 1'b0;
      for (waited = 0; pending_count != 0 && waited < DRAIN_LIMIT; waited++)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly requests from a few clients with time creeping forward, so records
   // fill up and block; occasional long jumps let windows and cleanups expire.
   task automatic random_item();
      logic [MODE_W-1:0]   mode;
      logic [CLIENT_W-1:0] client;
      logic [SLOT_W-1:0]   slot;
      int                  pick;
      pick = $urandom_range(99);
      if (pick < 80)      mode = MODE_REQUEST;
      else if (pick < 88) mode = MODE_CLEANUP;
      else if (pick < 96) mode = MODE_CLIENT_RESET;
      else                mode = MODE_UNUSED;
      if ($urandom_range(99) < 70) client = CLIENT_W'($urandom_range(2));
      else                         client = CLIENT_W'($urandom_range(CLIENTS - 1));
      pick = $urandom_range(99);
      if (pick < 85)      slot = SLOT_W'($urandom_range(LIMITED_SLOTS - 1));
      else if (pick < 95) slot = SLOT_W'(LIMITED_SLOTS);
      else                slot = SLOT_W'($urandom_range(7, LIMITED_SLOTS + 1));
      pick = $urandom_range(999);
      if (pick < 850)      sim_ms += $urandom_range(20);
      else if (pick < 970) sim_ms += $urandom_range(1500);
      else if (pick < 995) sim_ms += $urandom_range(70000);
      else                 sim_ms = $urandom();
      offer_item(mode, client, slot, sim_ms);
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = MODE_REQUEST;
      req_client_index  = '0;
      req_endpoint_slot = '0;
      req_now_ms        = '0;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      hold_off_pending  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      load_limits(LIMITS_DIRECTED);
      // Zero maximum blocks a fresh record, a window restart still lets one through.
      offer_item(MODE_REQUEST, 4'd0, 3'd0, 32'd0);
      offer_item(MODE_REQUEST, 4'd0, 3'd0, 32'd1);
      offer_item(MODE_REQUEST, 4'd0, 3'd0, 32'd1);
      // Unlimited slots are counted, not recorded; slot 2 then fills and restarts.
      offer_item(MODE_REQUEST, 4'd15, 3'd4, 32'd5);
      offer_item(MODE_REQUEST, 4'd3, 3'd7, 32'd5);
      offer_item(MODE_REQUEST, 4'd1, 3'd2, 32'd10);
      offer_item(MODE_REQUEST, 4'd1, 3'd2, 32'd10);
      offer_item(MODE_REQUEST, 4'd1, 3'd2, 32'd10);
      offer_item(MODE_REQUEST, 4'd1, 3'd2, 32'd111);
      // Elapsed time across the 32-bit wrap.
      offer_item(MODE_REQUEST, 4'd2, 3'd1, 32'hFFFF_FFF0);
      offer_item(MODE_REQUEST, 4'd2, 3'd1, 32'h0000_0010);
      offer_item(MODE_REQUEST, 4'd5, 3'd3, 32'hFFFF_FFFF);
      offer_item(MODE_REQUEST, 4'd5, 3'd3, 32'hFFFF_FFFF);
      // Cleanup too early, then one that drops every aged record.
      offer_item(MODE_CLEANUP, 4'd0, 3'd0, 32'd30000);
      offer_item(MODE_CLEANUP, 4'd0, 3'd0, 32'd70000);
      for (int s = 0; s < LIMITED_SLOTS; s++)
         offer_item(MODE_REQUEST, 4'd4, SLOT_W'(s), 32'd70000);
      offer_item(MODE_CLIENT_RESET, 4'd4, 3'd0, 32'd70000);
      offer_item(MODE_CLIENT_RESET, 4'd4, 3'd0, 32'd70000);
      offer_item(MODE_UNUSED, 4'd9, 3'd6, 32'hA5A5_5A5A);
      offer_item(MODE_CLEANUP, 4'd0, 3'd0, 32'd129999);
      offer_item(MODE_CLEANUP, 4'd0, 3'd0, 32'd130001);
      sim_ms = 32'd130001;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         load_limits(limit_style_t'(1 + (p + p / 4) % 4));
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
         endcase
         if (p % 4 == 0) hold_off_pending = 1'b1;
         repeat (ITEMS_PER_PHASE) random_item();
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
